// File: rtl/core/bate_pkg.sv
// Shared types, constants and tables of the bond angle triplet engine.
package bate_pkg;

	localparam int DEF_MAX_NEIGHBORS = 16;
	localparam int DEF_MAX_ELEMENTS  = 16;
	localparam int DEF_COORD_BITS    = 24;
	localparam int QUEUE_DEPTH       = 2;

	localparam int TYPE_W  = 4;
	localparam int NE_W    = 5;
	localparam int ANGLE_W = 18;
	localparam int OUT_W   = 32;

	localparam logic [NE_W-1:0]    NE_RESET    = 5'd1;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 18'd205887;
	localparam logic [27:0]        HALF_PI_Q24 = 28'd26353589;

	localparam int DIV_STEPS    = 30;
	localparam int SQRT_STEPS   = 31;
	localparam int CORDIC_STEPS = 24;

	typedef enum logic [2:0] {
		A_IDLE, A_MUL, A_PREP, A_DIV, A_SQR, A_SQRT, A_CORD, A_DONE
	} ang_state_t;

	typedef enum logic [2:0] {
		B_IDLE, B_READ, B_CHECK, B_WAIT, B_EMIT, B_MIRROR, B_FLUSH
	} back_state_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic [TYPE_W-1:0]  type_second;
		logic [TYPE_W-1:0]  type_center;
		logic [TYPE_W-1:0]  type_first;
	} res_t;

	function automatic logic [23:0] atan_q24(input logic [4:0] i);
		logic [23:0] a;
		unique case (i)
			5'd0:  a = 24'd13176795;
			5'd1:  a = 24'd7778716;
			5'd2:  a = 24'd4110060;
			5'd3:  a = 24'd2086331;
			5'd4:  a = 24'd1047214;
			5'd5:  a = 24'd524117;
			5'd6:  a = 24'd262123;
			5'd7:  a = 24'd131069;
			5'd8:  a = 24'd65536;
			5'd9:  a = 24'd32768;
			5'd10: a = 24'd16384;
			5'd11: a = 24'd8192;
			5'd12: a = 24'd4096;
			5'd13: a = 24'd2048;
			5'd14: a = 24'd1024;
			5'd15: a = 24'd512;
			5'd16: a = 24'd256;
			5'd17: a = 24'd128;
			5'd18: a = 24'd64;
			5'd19: a = 24'd32;
			5'd20: a = 24'd16;
			5'd21: a = 24'd8;
			5'd22: a = 24'd4;
			5'd23: a = 24'd2;
			default: a = 24'd0;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/core/bond_angle_triplet_engine.sv
// Bond angle triplet engine: one central atom's neighbors in, tagged bond angles out.
// Neighbors enter at up to one per cycle while the two-entry command queue has room;
// a neighbor arriving as number k is compared with each earlier stored neighbor j in
// ascending order, and every pair that passes the length and type checks runs
// through one shared iterative angle unit (the dot product and length product, a
// compare, 30 divide steps that are skipped when the cosine saturates, a squaring,
// 31 square root steps, 24 CORDIC steps and a done state). Each pair also passes the
// store read, the checks and one or two emit states, the second only when the types
// differ; a skipped earlier neighbor passes only the store read and the checks. The
// back part takes a new neighbor only when all pairs of the last are through, and it
// also waits while the result stream is stalled. Results leave through a one-entry
// hold and an output register, so tlast is set on the final angle of each
// neighbor. No clearing pass is needed after reset. The element type limit is written
// through the cfg channel and resets to 1.
module bond_angle_triplet_engine import bate_pkg::*; #(
	parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
	parameter int MAX_ELEMENTS  = DEF_MAX_ELEMENTS,
	parameter int COORD_BITS    = DEF_COORD_BITS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [NE_W-1:0]                            cfg_data,
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	// central_type, vec_x, vec_y, vec_z, bond_length, neighbor_type
	input  logic [((8 + 4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// first
	input  logic                                       s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	// type_first, type_center, type_second, angle, zero fill
	output logic [OUT_W-1:0]                           m_axis_tdata,
	output logic                                       m_axis_tlast
);
	localparam int IN_W  = ((8 + 4 * COORD_BITS + 7) / 8) * 8;
	localparam int KW    = $clog2(MAX_NEIGHBORS);
	localparam int CMD_W = 8 + 4 * COORD_BITS + KW;

	logic [NE_W-1:0]  type_limit_q;
	logic             q_push, q_full, q_pop, q_valid;
	logic [CMD_W-1:0] q_in, q_out;
	res_t             out_item;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {(OUT_W - $bits(res_t))'(0), out_item};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_limit_q <= NE_RESET;
		end else if (cfg_valid) begin
			type_limit_q <= cfg_data;
		end
	end

	bate_front #(
		.MAX_NEIGHBORS(MAX_NEIGHBORS),
		.COORD_BITS   (COORD_BITS),
		.IN_W         (IN_W),
		.KW           (KW),
		.CMD_W        (CMD_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tvalid   (s_axis_tvalid),
		.tready   (s_axis_tready),
		.tdata    (s_axis_tdata),
		.tuser    (s_axis_tuser),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full)
	);

	bate_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_out),
		.valid    (q_valid)
	);

	bate_back #(
		.MAX_NEIGHBORS(MAX_NEIGHBORS),
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.COORD_BITS   (COORD_BITS),
		.KW           (KW),
		.CMD_W        (CMD_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.type_limit(type_limit_q),
		.cmd_valid (q_valid),
		.cmd_data  (q_out),
		.cmd_pop   (q_pop),
		.out_item  (out_item),
		.out_last  (m_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

endmodule

// File: rtl/core/bate_fifo.sv
// Small command queue between the front and back parts.
module bate_fifo import bate_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             valid
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/bate_front.sv
// Front part: accepts neighbors, tracks the store fill and the central type.
module bate_front import bate_pkg::*; #(
	parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
	parameter int COORD_BITS    = DEF_COORD_BITS,
	parameter int IN_W          = ((8 + 4 * COORD_BITS + 7) / 8) * 8,
	parameter int KW            = $clog2(MAX_NEIGHBORS),
	parameter int CMD_W         = 8 + 4 * COORD_BITS + KW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tvalid,
	output logic             tready,
	input  logic [IN_W-1:0]  tdata,
	input  logic             tuser,
	output logic             push,
	output logic [CMD_W-1:0] push_data,
	input  logic             full
);
	localparam int CB = COORD_BITS;

	logic [KW:0]         cnt_q;
	logic [TYPE_W-1:0]   center_q;
	logic [KW:0]         eff_cnt;
	logic [TYPE_W-1:0]   center;
	logic                accept;
	logic                drop;

	assign tready  = !full;
	assign accept  = tvalid && !full;
	assign eff_cnt = tuser ? '0 : cnt_q;
	assign drop    = (eff_cnt == (KW+1)'(MAX_NEIGHBORS));
	assign center  = tuser ? tdata[TYPE_W-1:0] : center_q;
	assign push    = accept && !drop;

	assign push_data = {tdata[4 + 4 * CB +: TYPE_W], tdata[4 +: 4 * CB], center,
		eff_cnt[KW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			center_q <= '0;
		end else if (accept) begin
			if (!drop) begin
				cnt_q <= eff_cnt + 1'b1;
			end
			if (tuser) begin
				center_q <= tdata[TYPE_W-1:0];
			end
		end
	end

endmodule

// File: rtl/core/bate_angle.sv
// Iterative pair angle unit: dot product, divide, square root and CORDIC.
module bate_angle import bate_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [COORD_BITS-1:0] jx,
	input  logic signed [COORD_BITS-1:0] jy,
	input  logic signed [COORD_BITS-1:0] jz,
	input  logic        [COORD_BITS-1:0] jl,
	input  logic signed [COORD_BITS-1:0] kx,
	input  logic signed [COORD_BITS-1:0] ky,
	input  logic signed [COORD_BITS-1:0] kz,
	input  logic        [COORD_BITS-1:0] kl,
	output logic                         done,
	output logic [ANGLE_W-1:0]           angle
);
	localparam int CB = COORD_BITS;
	localparam int PW = 2 * CB + 2;
	localparam int AW = PW + 1;
	localparam int RW = 2 * CB + 1;

	ang_state_t state_q, state_d;

	logic signed [CB-1:0] jx_q, jy_q, jz_q, kx_q, ky_q, kz_q;
	logic        [CB-1:0] jl_q, kl_q;
	logic [4:0]           cnt_q;
	logic signed [AW-1:0] acc_q;
	logic [2*CB-1:0]      den_q;
	logic [RW-1:0]        r_q;
	logic [30:0]          cm_q;
	logic                 negc_q;
	logic [61:0]          v_q;
	logic [61:0]          res_q;
	logic signed [33:0]   x_q, y_q;
	logic signed [27:0]   z_q;

	logic signed [CB:0]   ma, mb;
	logic signed [PW-1:0] prod;
	logic [AW-1:0]        mag;
	logic [RW-1:0]        two_r;
	logic [61:0]          sbit;
	logic [61:0]          strial;
	logic [61:0]          res_nx;
	logic signed [33:0]   xs, ys;
	logic signed [27:0]   za;
	logic signed [27:0]   zr;
	logic signed [27:0]   zq;
	logic                 step_end;

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    begin ma = {jx_q[CB-1], jx_q}; mb = {kx_q[CB-1], kx_q}; end
			2'd1:    begin ma = {jy_q[CB-1], jy_q}; mb = {ky_q[CB-1], ky_q}; end
			2'd2:    begin ma = {jz_q[CB-1], jz_q}; mb = {kz_q[CB-1], kz_q}; end
			default: begin ma = {1'b0, jl_q};       mb = {1'b0, kl_q};       end
		endcase
	end

	assign prod   = ma * mb;
	assign mag    = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
	assign two_r  = {r_q[RW-2:0], 1'b0};
	assign sbit   = 62'(1) << (6'd60 - {cnt_q, 1'b0});
	assign strial = res_q + sbit;
	assign res_nx = (v_q >= strial) ? (res_q >> 1) + sbit : (res_q >> 1);
	assign xs     = x_q >>> cnt_q;
	assign ys     = y_q >>> cnt_q;
	assign za     = $signed({4'd0, atan_q24(cnt_q)});
	assign zr     = z_q + 28'sd128;
	assign zq     = zr >>> 8;

	always_comb begin
		state_d  = state_q;
		done     = 1'b0;
		step_end = 1'b0;
		unique case (state_q)
			A_IDLE: if (start) state_d = A_MUL;
			A_MUL:  if (cnt_q == 5'd3) state_d = A_PREP;
			A_PREP: state_d = (mag >= AW'(den_q)) ? A_SQR : A_DIV;
			A_DIV:  if (cnt_q == 5'(DIV_STEPS - 1)) state_d = A_SQR;
			A_SQR:  state_d = A_SQRT;
			A_SQRT: if (cnt_q == 5'(SQRT_STEPS - 1)) state_d = A_CORD;
			A_CORD: if (cnt_q == 5'(CORDIC_STEPS - 1)) state_d = A_DONE;
			A_DONE: begin
				done     = 1'b1;
				step_end = 1'b1;
				state_d  = A_IDLE;
			end
			default: state_d = A_IDLE;
		endcase
	end

	always_comb begin
		if (zr < 0) begin
			angle = '0;
		end else if (zq > $signed({10'd0, ANGLE_MAX})) begin
			angle = ANGLE_MAX;
		end else begin
			angle = zq[ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q != state_d || step_end) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 1'b1;
		end
		unique case (state_q)
			A_IDLE: begin
				jx_q  <= jx;
				jy_q  <= jy;
				jz_q  <= jz;
				jl_q  <= jl;
				kx_q  <= kx;
				ky_q  <= ky;
				kz_q  <= kz;
				kl_q  <= kl;
				acc_q <= '0;
			end
			A_MUL: begin
				if (cnt_q == 5'd3) begin
					den_q <= prod[2*CB-1:0];
				end else begin
					acc_q <= acc_q + AW'(prod);
				end
			end
			A_PREP: begin
				negc_q <= acc_q[AW-1];
				r_q    <= mag[RW-1:0];
				cm_q   <= (mag >= AW'(den_q)) ? 31'h4000_0000 : '0;
			end
			A_DIV: begin
				if (two_r >= RW'(den_q)) begin
					r_q  <= two_r - RW'(den_q);
					cm_q <= {cm_q[29:0], 1'b1};
				end else begin
					r_q  <= two_r;
					cm_q <= {cm_q[29:0], 1'b0};
				end
			end
			A_SQR: begin
				v_q   <= (62'(1) << 60) - (62'(cm_q) * 62'(cm_q));
				res_q <= '0;
			end
			A_SQRT: begin
				if (v_q >= strial) begin
					v_q <= v_q - strial;
				end
				res_q <= res_nx;
				if (cnt_q == 5'(SQRT_STEPS - 1)) begin
					x_q <= negc_q ? $signed({3'd0, res_nx[30:0]}) : $signed({3'd0, cm_q});
					y_q <= negc_q ? $signed({3'd0, cm_q}) : $signed({3'd0, res_nx[30:0]});
					z_q <= negc_q ? $signed(HALF_PI_Q24) : '0;
				end
			end
			A_CORD: begin
				if (y_q >= 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + za;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - za;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/core/bate_back.sv
// Back part: neighbor store, pair walk, result hold and output register.
module bate_back import bate_pkg::*; #(
	parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
	parameter int MAX_ELEMENTS  = DEF_MAX_ELEMENTS,
	parameter int COORD_BITS    = DEF_COORD_BITS,
	parameter int KW            = $clog2(MAX_NEIGHBORS),
	parameter int CMD_W         = 8 + 4 * COORD_BITS + KW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [NE_W-1:0]  type_limit,
	input  logic             cmd_valid,
	input  logic [CMD_W-1:0] cmd_data,
	output logic             cmd_pop,
	output res_t             out_item,
	output logic             out_last,
	output logic             out_valid,
	input  logic             out_ready
);
	localparam int CB = COORD_BITS;

	back_state_t state_q, state_d;

	logic signed [CB-1:0] sx_q [MAX_NEIGHBORS];
	logic signed [CB-1:0] sy_q [MAX_NEIGHBORS];
	logic signed [CB-1:0] sz_q [MAX_NEIGHBORS];
	logic        [CB-1:0] sl_q [MAX_NEIGHBORS];
	logic [TYPE_W-1:0]    st_q [MAX_NEIGHBORS];

	logic signed [CB-1:0] rx_q, ry_q, rz_q, kx_q, ky_q, kz_q;
	logic        [CB-1:0] rl_q, kl_q;
	logic [TYPE_W-1:0]    rt_q, nt_q, ctr_q;
	logic [KW-1:0]        k_q, j_q;
	logic [ANGLE_W-1:0]   ang_q;
	res_t                 hold_q, out_q;
	logic                 hold_v_q, out_v_q, out_last_q;

	logic [KW-1:0]        c_k;
	logic [TYPE_W-1:0]    c_ctr, c_nt;
	logic signed [CB-1:0] c_x, c_y, c_z;
	logic        [CB-1:0] c_l;

	logic       rd_en, start, push, flush, j_step, last_j, out_free, can_push, done;
	res_t       push_item;
	logic [ANGLE_W-1:0] angle;

	function automatic logic type_ok(input logic [TYPE_W-1:0] t,
		input logic [NE_W-1:0] ne);
		return (NE_W'(t) < ne) && (int'(t) < MAX_ELEMENTS);
	endfunction

	assign c_k   = cmd_data[KW-1:0];
	assign c_ctr = cmd_data[KW +: TYPE_W];
	assign c_x   = cmd_data[KW + 4 +: CB];
	assign c_y   = cmd_data[KW + 4 + CB +: CB];
	assign c_z   = cmd_data[KW + 4 + 2 * CB +: CB];
	assign c_l   = cmd_data[KW + 4 + 3 * CB +: CB];
	assign c_nt  = cmd_data[KW + 4 + 4 * CB +: TYPE_W];

	assign last_j   = ((KW+1)'(j_q) + 1'b1) == {1'b0, k_q};
	assign out_free = !out_v_q || out_ready;
	assign can_push = !hold_v_q || out_free;

	assign out_item  = out_q;
	assign out_last  = out_last_q;
	assign out_valid = out_v_q;

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		rd_en     = 1'b0;
		start     = 1'b0;
		push      = 1'b0;
		flush     = 1'b0;
		j_step    = 1'b0;
		push_item = '{angle: ang_q, type_second: nt_q, type_center: ctr_q, type_first: rt_q};
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (type_ok(c_ctr, type_limit) && c_l != '0 &&
						type_ok(c_nt, type_limit) && c_k != '0) begin
						state_d = B_READ;
					end
				end
			end
			B_READ: begin
				rd_en   = 1'b1;
				state_d = B_CHECK;
			end
			B_CHECK: begin
				if (rl_q != '0 && type_ok(rt_q, type_limit)) begin
					start   = 1'b1;
					state_d = B_WAIT;
				end else begin
					j_step  = 1'b1;
					state_d = last_j ? B_FLUSH : B_READ;
				end
			end
			B_WAIT: if (done) state_d = B_EMIT;
			B_EMIT: begin
				if (can_push) begin
					push = 1'b1;
					if (rt_q != nt_q) begin
						state_d = B_MIRROR;
					end else begin
						j_step  = 1'b1;
						state_d = last_j ? B_FLUSH : B_READ;
					end
				end
			end
			B_MIRROR: begin
				push_item = '{angle: ang_q, type_second: rt_q, type_center: ctr_q,
					type_first: nt_q};
				if (can_push) begin
					push    = 1'b1;
					j_step  = 1'b1;
					state_d = last_j ? B_FLUSH : B_READ;
				end
			end
			B_FLUSH: begin
				if (!hold_v_q) begin
					state_d = B_IDLE;
				end else if (out_free) begin
					flush   = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	bate_angle #(
		.COORD_BITS(COORD_BITS)
	) u_angle (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.jx    (rx_q),
		.jy    (ry_q),
		.jz    (rz_q),
		.jl    (rl_q),
		.kx    (kx_q),
		.ky    (ky_q),
		.kz    (kz_q),
		.kl    (kl_q),
		.done  (done),
		.angle (angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				hold_v_q <= 1'b1;
			end else if (flush) begin
				hold_v_q <= 1'b0;
			end
			if ((push && hold_v_q) || flush) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			sx_q[c_k] <= c_x;
			sy_q[c_k] <= c_y;
			sz_q[c_k] <= c_z;
			sl_q[c_k] <= c_l;
			st_q[c_k] <= c_nt;
			kx_q      <= c_x;
			ky_q      <= c_y;
			kz_q      <= c_z;
			kl_q      <= c_l;
			nt_q      <= c_nt;
			ctr_q     <= c_ctr;
			k_q       <= c_k;
			j_q       <= '0;
		end else if (j_step) begin
			j_q <= j_q + 1'b1;
		end
		if (rd_en) begin
			rx_q <= sx_q[j_q];
			ry_q <= sy_q[j_q];
			rz_q <= sz_q[j_q];
			rl_q <= sl_q[j_q];
			rt_q <= st_q[j_q];
		end
		if (done) begin
			ang_q <= angle;
		end
		if (push) begin
			hold_q <= push_item;
			if (hold_v_q) begin
				out_q      <= hold_q;
				out_last_q <= 1'b0;
			end
		end
		if (flush) begin
			out_q      <= hold_q;
			out_last_q <= 1'b1;
		end
	end

endmodule

// File: rtl/core/bate_checker.sv
// Port-level checks on the result stream, bound to the top level.
module bate_checker import bate_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic             m_axis_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result transaction withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result transaction changed");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[29:12] <= ANGLE_MAX)
		else $error("angle above pi");

	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:30] == 2'b00)
		else $error("fill bits of result set");

endmodule

bind bond_angle_triplet_engine bate_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);
